>>> hw/rtl/ppcrp_pkg.sv
// Shared types, relocation codes and veneer constants for the relocation patcher.
package ppcrp_pkg;

	// input word: one relocation record
	typedef struct packed {
		logic               op;
		logic [7:0]         reloc_type;
		logic [31:0]        section_base;
		logic [31:0]        place_offset;
		logic signed [31:0] addend;
		logic [31:0]        symbol_value;
		logic [31:0]        old_word;
	} req_t;

	// output word: one memory write (or a write-free status)
	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  write_size;
		logic [31:0] write_addr;
		logic [31:0] write_data;
		logic        last;
	} res_t;

	// classified command between front and back
	typedef struct packed {
		logic        far;     // branch needs a veneer
		logic        is14;    // 14-bit branch field
		logic [2:0]  status;
		logic [1:0]  size;
		logic [31:0] addr;
		logic [31:0] data;    // final data, or old word with field cleared when far
		logic [31:0] target;  // S + A, veneer target
		logic [31:0] adj;     // added to veneer address to form the branch field
	} cmd_t;

	localparam logic OP_APPLY = 1'b0;
	localparam logic OP_SIZE  = 1'b1;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_CACHE  = 3'd1;
	localparam logic [2:0] ST_ADD    = 3'd2;
	localparam logic [2:0] ST_NOROOM = 3'd3;
	localparam logic [2:0] ST_UNSUP  = 3'd4;

	localparam logic [1:0] SZ_NONE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;
	localparam logic [1:0] SZ_WORD = 2'd2;

	localparam logic [7:0] R_NONE       = 8'd0;
	localparam logic [7:0] R_ADDR32     = 8'd1;
	localparam logic [7:0] R_ADDR24     = 8'd2;
	localparam logic [7:0] R_ADDR16_LO  = 8'd4;
	localparam logic [7:0] R_ADDR16_HI  = 8'd5;
	localparam logic [7:0] R_ADDR16_HA  = 8'd6;
	localparam logic [7:0] R_ADDR14     = 8'd7;
	localparam logic [7:0] R_REL24      = 8'd10;
	localparam logic [7:0] R_REL14      = 8'd11;
	localparam logic [7:0] R_REL32      = 8'd26;
	localparam logic [7:0] R_SDAREL16   = 8'd32;
	localparam logic [7:0] R_TPREL16_LO = 8'd70;
	localparam logic [7:0] R_TPREL16_HI = 8'd71;
	localparam logic [7:0] R_TPREL16_HA = 8'd72;

	localparam logic [1:0] CFG_SMALL_BASE  = 2'd0;
	localparam logic [1:0] CFG_TRAMP_START = 2'd1;
	localparam logic [1:0] CFG_TRAMP_END   = 2'd2;

	localparam logic [31:0] INSN_LIS   = 32'h3d800000;
	localparam logic [31:0] INSN_ORI   = 32'h618c0000;
	localparam logic [31:0] INSN_MTCTR = 32'h7d8903a6;
	localparam logic [31:0] INSN_BCTR  = 32'h4e800420;
	localparam logic [31:0] MASK14     = 32'h0000fffc;
	localparam logic [31:0] MASK24     = 32'h03fffffc;
	localparam logic [32:0] VENEER_BYTES = 33'd16;

	// veneer sequencing: four instruction words then the branch word
	localparam logic [2:0] VS_LIS    = 3'd0;
	localparam logic [2:0] VS_ORI    = 3'd1;
	localparam logic [2:0] VS_MTCTR  = 3'd2;
	localparam logic [2:0] VS_BCTR   = 3'd3;
	localparam logic [2:0] VS_BRANCH = 3'd4;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

endpackage

>>> hw/rtl/ppc_relocation_patcher_top.sv
// Top level of the PowerPC RELA relocation patcher.
// Usage:
//  - Input channel (push/full/req): one relocation record per word, accepted
//    at an edge with push high and full low.
//  - Result channel (empty/pop/res): the oldest result sits on res while
//    empty is low; it is taken at an edge with pop high.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is
//    always high. Index 0 small data base, 1 trampoline start (also reloads
//    the trampoline pointer), 2 trampoline end; other indexes are dropped.
//    Write config only while the block is idle.
// Timing:
//  - Front: one register stage computes P and S+A, classification feeds a
//    two-entry command queue; back: one result per cycle into the output reg
//    while the receiver pops. A record passes front reg, queue, output reg.
//  - Throughput: one record per cycle when each gives one result and res is
//    popped; veneer words leave one by one while the front fills the queue.
//  - A stalled receiver holds res; the queue and front register absorb up
//    to three records before full rises.
// Reset: config registers and trampoline pointer clear to zero, queue and stages empty.
module ppc_relocation_patcher_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  ppcrp_pkg::req_t req,
	output logic            empty,
	input  logic            pop,
	output ppcrp_pkg::res_t res,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [31:0]     cfg_data
);

	logic [31:0]     small_base_q;
	logic [31:0]     tramp_end_q;
	logic            cfg_wr;
	logic            tnext_load;

	logic            q_push;
	logic            q_full;
	logic            q_pop;
	logic            q_empty;
	ppcrp_pkg::cmd_t q_wdata;
	ppcrp_pkg::cmd_t q_head;

	assign cfg_ready  = 1'b1;
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign tnext_load = cfg_wr && (cfg_index == ppcrp_pkg::CFG_TRAMP_START);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_base_q <= 32'd0;
			tramp_end_q  <= 32'd0;
		end else if (cfg_wr) begin
			case (cfg_index)
				ppcrp_pkg::CFG_SMALL_BASE: small_base_q <= cfg_data;
				ppcrp_pkg::CFG_TRAMP_END:  tramp_end_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	ppcrp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.req        (req),
		.small_base (small_base_q),
		.cmd_push   (q_push),
		.cmd_full   (q_full),
		.cmd        (q_wdata)
	);

	ppcrp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.full   (q_full),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.empty  (q_empty),
		.head   (q_head)
	);

	ppcrp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_empty   (q_empty),
		.cmd_pop     (q_pop),
		.cmd         (q_head),
		.tnext_load  (tnext_load),
		.tnext_value (cfg_data),
		.tramp_end   (tramp_end_q),
		.empty       (empty),
		.pop         (pop),
		.res         (res)
	);

endmodule

>>> hw/rtl/ppcrp_front.sv
// Front end: registers a relocation record and classifies it into a command.
module ppcrp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  ppcrp_pkg::req_t    req,
	input  logic [31:0]        small_base,
	output logic               cmd_push,
	input  logic               cmd_full,
	output ppcrp_pkg::cmd_t    cmd
);

	logic            valid_s1;
	ppcrp_pkg::req_t req_s1;
	logic [31:0]     p_s1;
	logic [31:0]     sa_s1;

	logic        adv;
	logic        accept;
	logic        sizing;
	logic        rel;
	logic        is14;
	logic        far;
	logic        half;
	logic [15:0] hw;
	logic [31:0] d;
	logic [31:0] sda;
	logic [15:0] ha;
	logic [31:0] mask;
	logic [31:0] field;

	assign adv      = !valid_s1 || !cmd_full;
	assign full     = !adv;
	assign accept   = push && !full;
	assign cmd_push = valid_s1 && !cmd_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
			p_s1   <= req.section_base + req.place_offset;
			sa_s1  <= req.symbol_value + req.addend;
		end
	end

	always_comb begin
		sizing = (req_s1.op == ppcrp_pkg::OP_SIZE);
		d      = sa_s1 - p_s1;
		sda    = sa_s1 - small_base;
		ha     = sa_s1[31:16] + {15'd0, sa_s1[15]};
		rel    = req_s1.reloc_type inside {ppcrp_pkg::R_REL24, ppcrp_pkg::R_REL14};
		is14   = req_s1.reloc_type inside {ppcrp_pkg::R_ADDR14, ppcrp_pkg::R_REL14};
		mask   = is14 ? ppcrp_pkg::MASK14 : ppcrp_pkg::MASK24;
		field  = rel ? d : sa_s1;
		// relative: signed displacement must sign-extend from bit 15 / 25
		// absolute: (S+A)>>2 must fit unsigned in 14 / 24 bits
		if (rel) begin
			far = is14 ? !((&d[31:15]) || !(|d[31:15]))
				: !((&d[31:25]) || !(|d[31:25]));
		end else begin
			far = is14 ? (|sa_s1[31:16]) : (|sa_s1[31:26]);
		end
		half = 1'b0;
		hw   = 16'd0;

		cmd        = '0;
		cmd.status = ppcrp_pkg::ST_OK;
		cmd.size   = ppcrp_pkg::SZ_NONE;
		cmd.is14   = is14;

		case (req_s1.reloc_type)
			ppcrp_pkg::R_NONE: begin
				cmd.status = ppcrp_pkg::ST_OK;
			end
			ppcrp_pkg::R_ADDR32, ppcrp_pkg::R_REL32: begin
				if (!sizing) begin
					cmd.size = ppcrp_pkg::SZ_WORD;
					cmd.addr = p_s1;
					cmd.data = (req_s1.reloc_type == ppcrp_pkg::R_ADDR32) ? sa_s1 : d;
				end
			end
			ppcrp_pkg::R_ADDR16_LO, ppcrp_pkg::R_TPREL16_LO: begin
				half = 1'b1;
				hw   = sa_s1[15:0];
			end
			ppcrp_pkg::R_ADDR16_HI, ppcrp_pkg::R_TPREL16_HI: begin
				half = 1'b1;
				hw   = sa_s1[31:16];
			end
			ppcrp_pkg::R_ADDR16_HA, ppcrp_pkg::R_TPREL16_HA: begin
				half = 1'b1;
				hw   = ha;
			end
			ppcrp_pkg::R_SDAREL16: begin
				half = 1'b1;
				hw   = sda[15:0];
			end
			ppcrp_pkg::R_ADDR24, ppcrp_pkg::R_ADDR14,
			ppcrp_pkg::R_REL24, ppcrp_pkg::R_REL14: begin
				if (sizing && (req_s1.section_base == 32'd0)) begin
					cmd.status = ppcrp_pkg::ST_CACHE;
				end else if (sizing) begin
					cmd.status = far ? ppcrp_pkg::ST_ADD : ppcrp_pkg::ST_OK;
				end else if (!far) begin
					cmd.size = ppcrp_pkg::SZ_WORD;
					cmd.addr = p_s1;
					cmd.data = (req_s1.old_word & ~mask) | (field & mask);
				end else begin
					cmd.far    = 1'b1;
					cmd.size   = ppcrp_pkg::SZ_WORD;
					cmd.addr   = p_s1;
					cmd.data   = req_s1.old_word & ~mask;
					cmd.target = sa_s1;
					cmd.adj    = rel ? (req_s1.addend - p_s1) : req_s1.addend;
				end
			end
			default: begin
				cmd.status = ppcrp_pkg::ST_UNSUP;
			end
		endcase

		if (half && !sizing) begin
			cmd.size = ppcrp_pkg::SZ_HALF;
			cmd.addr = p_s1;
			cmd.data = {16'd0, hw};
		end
	end

endmodule

>>> hw/rtl/ppcrp_queue.sv
// Short command queue between the front and back ends.
module ppcrp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  ppcrp_pkg::cmd_t wdata,
	input  logic            pop,
	output logic            empty,
	output ppcrp_pkg::cmd_t head
);

	ppcrp_pkg::cmd_t                   mem_q [ppcrp_pkg::QDEPTH];
	logic [ppcrp_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [ppcrp_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [ppcrp_pkg::QPTR_W:0]        cnt_q;
	logic                              do_push;
	logic                              do_pop;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == (ppcrp_pkg::QPTR_W+1)'(ppcrp_pkg::QDEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> hw/rtl/ppcrp_back.sv
// Back end: trampoline pointer, veneer sequencing and the output register.
module ppcrp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_empty,
	output logic            cmd_pop,
	input  ppcrp_pkg::cmd_t cmd,
	input  logic            tnext_load,
	input  logic [31:0]     tnext_value,
	input  logic [31:0]     tramp_end,
	output logic            empty,
	input  logic            pop,
	output ppcrp_pkg::res_t res
);

	logic [31:0]     tnext_q;
	logic [2:0]      step_q;
	logic            out_valid_q;
	ppcrp_pkg::res_t out_q;

	logic            adv;
	logic            go;
	logic            room;
	logic            done;
	logic [31:0]     mask;
	logic [31:0]     field;
	ppcrp_pkg::res_t nxt;

	assign adv     = !out_valid_q || pop;
	assign go      = !cmd_empty && adv;
	assign cmd_pop = go && done;
	assign empty   = !out_valid_q;
	assign res     = out_q;

	always_comb begin
		room  = ({1'b0, tnext_q} + ppcrp_pkg::VENEER_BYTES) <= {1'b0, tramp_end};
		mask  = cmd.is14 ? ppcrp_pkg::MASK14 : ppcrp_pkg::MASK24;
		field = tnext_q + cmd.adj;
		done  = 1'b1;

		nxt            = '0;
		nxt.status     = cmd.status;
		nxt.write_size = cmd.size;
		nxt.write_addr = cmd.addr;
		nxt.write_data = cmd.data;
		nxt.last       = 1'b1;

		if (cmd.far) begin
			nxt.status     = ppcrp_pkg::ST_OK;
			nxt.write_size = ppcrp_pkg::SZ_WORD;
			nxt.write_addr = tnext_q + {27'd0, step_q, 2'b00};
			nxt.last       = 1'b0;
			done           = 1'b0;
			case (step_q)
				ppcrp_pkg::VS_LIS: begin
					if (!room) begin
						nxt.status     = ppcrp_pkg::ST_NOROOM;
						nxt.write_size = ppcrp_pkg::SZ_NONE;
						nxt.write_addr = 32'd0;
						nxt.write_data = 32'd0;
						nxt.last       = 1'b1;
						done           = 1'b1;
					end else begin
						nxt.write_data = ppcrp_pkg::INSN_LIS | {16'd0, cmd.target[31:16]};
					end
				end
				ppcrp_pkg::VS_ORI: begin
					nxt.write_data = ppcrp_pkg::INSN_ORI | {16'd0, cmd.target[15:0]};
				end
				ppcrp_pkg::VS_MTCTR: begin
					nxt.write_data = ppcrp_pkg::INSN_MTCTR;
				end
				ppcrp_pkg::VS_BCTR: begin
					nxt.write_data = ppcrp_pkg::INSN_BCTR;
				end
				default: begin
					nxt.write_addr = cmd.addr;
					nxt.write_data = cmd.data | (field & mask);
					nxt.last       = 1'b1;
					done           = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tnext_q     <= 32'd0;
			step_q      <= ppcrp_pkg::VS_LIS;
			out_valid_q <= 1'b0;
		end else begin
			if (tnext_load) begin
				tnext_q <= tnext_value;
			end else if (go && cmd.far && (step_q == ppcrp_pkg::VS_BRANCH)) begin
				tnext_q <= tnext_q + ppcrp_pkg::VENEER_BYTES[31:0];
			end
			if (go && cmd.far) begin
				step_q <= done ? ppcrp_pkg::VS_LIS : step_q + 3'd1;
			end
			if (adv) begin
				out_valid_q <= go;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_q <= nxt;
		end
	end

endmodule

>>> hw/rtl/ppcrp_checker.sv
// Port-level checks for the relocation patcher, bound to the top level.
module ppcrp_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            empty,
	input logic            pop,
	input ppcrp_pkg::res_t res
);

	// a waiting result is not withdrawn or changed
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(res))
		else $error("result changed while stalled");

	// write-free results carry zero address and data
	a_nowrite_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (res.write_size == ppcrp_pkg::SZ_NONE) |->
		(res.write_addr == 32'd0) && (res.write_data == 32'd0))
		else $error("write-free result carries address or data");

	// only veneer words are non-final, and they are plain word writes
	a_mid_word: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !res.last |->
		(res.write_size == ppcrp_pkg::SZ_WORD) && (res.status == ppcrp_pkg::ST_OK))
		else $error("non-final result is not a veneer word");

	// a veneer word is followed right away by another word of the same record
	a_veneer_cont: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !res.last |=> !empty)
		else $error("veneer sequence broken");

	// error statuses never write
	a_err_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (res.status != ppcrp_pkg::ST_OK) |->
		(res.write_size == ppcrp_pkg::SZ_NONE) && res.last)
		else $error("status result with a write");

endmodule

bind ppc_relocation_patcher_top ppcrp_checker u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.res    (res)
);

>>> tb/sv/tb_top.sv
// Self-checking testbench for the PowerPC RELA relocation patcher.
`timescale 1ns / 100ps

module tb_top;
	import ppcrp_pkg::*;

	// index 3 is not decoded by the block; writes to it must be dropped
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	// place used by the directed records: P = D_BASE + D_OFF
	localparam logic [31:0] D_BASE = 32'h0010_0000;
	localparam logic [31:0] D_OFF  = 32'h0000_0100;
	localparam logic [31:0] D_P    = D_BASE + D_OFF;

	// a record waiting to go in; drain_first holds it back until every
	// expected word of the earlier records has been popped
	typedef struct packed {
		logic drain_first;
		req_t rec;
	} backlog_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        push      = 1'b0;
	logic        full;
	req_t        req       = '0;
	logic        empty;
	logic        pop       = 1'b0;
	res_t        res;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data  = '0;

	backlog_t reloc_backlog[$];
	res_t     patch_writes_due[$];

	// shadow copy of the block's registers and trampoline pointer
	logic [31:0] small_base = '0;
	logic [31:0] tramp_end  = '0;
	logic [31:0] tramp_ptr  = '0;

	logic rec_taken = 1'b0;  // the word on req went in at the last rising edge
	bit   calm      = 1'b0;  // final stretch: no idling on either side
	int   push_gap  = 0;
	int   pop_gap   = 0;

	int mismatch_cnt   = 0;
	int records_sent   = 0;
	int words_checked  = 0;
	int veneers_placed = 0;
	int room_refusals  = 0;
	int sizing_records = 0;
	int reg_writes     = 0;

	ppc_relocation_patcher_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req      (req),
		.empty    (empty),
		.pop      (pop),
		.res      (res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	// generous cap; a correct run needs well under a millisecond
	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: word %0d: %s got %h expected %h", $time, words_checked, what,
			got, want);
		mismatch_cnt++;
	endtask

	function automatic res_t patch_word(input logic [2:0] st, input logic [1:0] sz,
			input logic [31:0] addr, input logic [31:0] data, input logic lst);
		res_t w;
		w.status     = st;
		w.write_size = sz;
		w.write_addr = addr;
		w.write_data = data;
		w.last       = lst;
		return w;
	endfunction

	// Works out the words one record produces and advances the shadow
	// trampoline pointer when a veneer gets placed.
	task automatic predict_patch(input req_t r);
		logic [31:0] p, sa, d, lim, fld, msk, at, half;
		logic sizing, rel, is14, far;
		p      = r.section_base + r.place_offset;
		sa     = r.symbol_value + $unsigned(r.addend);
		sizing = (r.op == OP_SIZE);
		if (sizing)
			sizing_records++;
		case (r.reloc_type)
		R_NONE: patch_writes_due.push_back(patch_word(ST_OK, SZ_NONE, '0, '0, 1'b1));
		R_ADDR32, R_REL32: begin
			if (sizing)
				patch_writes_due.push_back(patch_word(ST_OK, SZ_NONE, '0, '0, 1'b1));
			else
				patch_writes_due.push_back(patch_word(ST_OK, SZ_WORD, p,
					(r.reloc_type == R_ADDR32) ? sa : sa - p, 1'b1));
		end
		R_ADDR16_LO, R_ADDR16_HI, R_ADDR16_HA, R_SDAREL16,
		R_TPREL16_LO, R_TPREL16_HI, R_TPREL16_HA: begin
			case (r.reloc_type)
			R_ADDR16_LO, R_TPREL16_LO: half = {16'h0, sa[15:0]};
			R_ADDR16_HI, R_TPREL16_HI: half = {16'h0, sa[31:16]};
			// high adjusted: round up when the low half reads as negative
			R_ADDR16_HA, R_TPREL16_HA: half = {16'h0, sa[31:16] + {15'h0, sa[15]}};
			default: half = {16'h0, sa[15:0] - small_base[15:0]};
			endcase
			if (sizing)
				patch_writes_due.push_back(patch_word(ST_OK, SZ_NONE, '0, '0, 1'b1));
			else
				patch_writes_due.push_back(patch_word(ST_OK, SZ_HALF, p, half, 1'b1));
		end
		R_ADDR24, R_ADDR14, R_REL24, R_REL14: begin
			rel  = (r.reloc_type == R_REL24) || (r.reloc_type == R_REL14);
			is14 = (r.reloc_type == R_ADDR14) || (r.reloc_type == R_REL14);
			msk  = is14 ? MASK14 : MASK24;
			if (rel) begin
				// signed reach: -lim .. lim-1 bytes, tested with one wrapped compare
				d   = sa - p;
				lim = is14 ? 32'h0000_8000 : 32'h0200_0000;
				far = (d + lim) >= (lim << 1);
				fld = d;
			end else begin
				far = (sa >> 2) > (is14 ? 32'h0000_3fff : 32'h00ff_ffff);
				fld = sa;
			end
			if (sizing && r.section_base == '0) begin
				patch_writes_due.push_back(patch_word(ST_CACHE, SZ_NONE, '0, '0, 1'b1));
			end else if (sizing) begin
				patch_writes_due.push_back(patch_word(far ? ST_ADD : ST_OK, SZ_NONE,
					'0, '0, 1'b1));
			end else if (far && ({1'b0, tramp_ptr} + VENEER_BYTES > {1'b0, tramp_end})) begin
				// room check is done without wrap, so an area at the top of memory
				// may refuse even a first veneer
				patch_writes_due.push_back(patch_word(ST_NOROOM, SZ_NONE, '0, '0, 1'b1));
				room_refusals++;
			end else begin
				if (far) begin
					at = tramp_ptr;
					patch_writes_due.push_back(patch_word(ST_OK, SZ_WORD, at,
						INSN_LIS | {16'h0, sa[31:16]}, 1'b0));
					patch_writes_due.push_back(patch_word(ST_OK, SZ_WORD, at + 32'd4,
						INSN_ORI | {16'h0, sa[15:0]}, 1'b0));
					patch_writes_due.push_back(patch_word(ST_OK, SZ_WORD, at + 32'd8,
						INSN_MTCTR, 1'b0));
					patch_writes_due.push_back(patch_word(ST_OK, SZ_WORD, at + 32'd12,
						INSN_BCTR, 1'b0));
					tramp_ptr = at + 32'd16;
					veneers_placed++;
					// addend is added to the veneer address, as the loader does
					fld = rel ? at + $unsigned(r.addend) - p : at + $unsigned(r.addend);
				end
				patch_writes_due.push_back(patch_word(ST_OK, SZ_WORD, p,
					(r.old_word & ~msk) | (fld & msk), 1'b1));
			end
		end
		default: patch_writes_due.push_back(patch_word(ST_UNSUP, SZ_NONE, '0, '0, 1'b1));
		endcase
	endtask

	task automatic check_word(input res_t got);
		res_t want;
		words_checked++;
		if (patch_writes_due.size() == 0) begin
			report_mismatch("word with nothing expected, data", got.write_data, '0);
		end else begin
			want = patch_writes_due.pop_front();
			if (got.status !== want.status)
				report_mismatch("status", 32'(got.status), 32'(want.status));
			if (got.write_size !== want.write_size)
				report_mismatch("write_size", 32'(got.write_size), 32'(want.write_size));
			if (got.write_addr !== want.write_addr)
				report_mismatch("write_addr", got.write_addr, want.write_addr);
			if (got.write_data !== want.write_data)
				report_mismatch("write_data", got.write_data, want.write_data);
			if (got.last !== want.last)
				report_mismatch("last", 32'(got.last), 32'(want.last));
		end
	endtask

	// Monitor: both handshakes are sampled at the rising edge.
	always @(posedge clk) begin
		rec_taken <= push && !full;
		if (arst_n && push && !full) begin
			predict_patch(req);
			records_sent++;
		end
		if (arst_n && pop && !empty)
			check_word(res);
	end

	// Record driver: holds a word until it is taken, then either idles for a
	// burst or presents the next one from the backlog.
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || rec_taken) begin
			if (push_gap != 0) begin
				push_gap--;
				push <= 1'b0;
			end else if (reloc_backlog.size() == 0) begin
				push <= 1'b0;
			end else if (reloc_backlog[0].drain_first && patch_writes_due.size() != 0) begin
				push <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				push_gap = $urandom_range(0, 18);
				push <= 1'b0;
			end else begin
				req  <= reloc_backlog[0].rec;
				push <= 1'b1;
				reloc_backlog.pop_front();
			end
		end
	end

	// Result receiver: random stall bursts, pop held high otherwise.
	always @(negedge clk) begin
		if (pop_gap != 0) begin
			pop_gap--;
			pop <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			pop_gap = $urandom_range(0, 18);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// One register write; the shadow copy follows at the accepting edge.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		CFG_SMALL_BASE: small_base = val;
		CFG_TRAMP_START: tramp_ptr = val;  // start also reloads the pointer
		CFG_TRAMP_END: tramp_end = val;
		default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Block is idle once nothing is pending or expected; every record gives
	// at least one word, so a few extra cycles cover the pipeline.
	task automatic wait_idle();
		while (reloc_backlog.size() != 0 || push || patch_writes_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic req_t reloc_rec(input logic op, input logic [7:0] t,
			input logic [31:0] base, input logic [31:0] off, input logic [31:0] a,
			input logic [31:0] sym, input logic [31:0] old);
		req_t r;
		r.op           = op;
		r.reloc_type   = t;
		r.section_base = base;
		r.place_offset = off;
		r.addend       = a;
		r.symbol_value = sym;
		r.old_word     = old;
		return r;
	endfunction

	task automatic queue_rec(input req_t r);
		backlog_t slot;
		slot.drain_first = 1'b0;
		slot.rec         = r;
		reloc_backlog.push_back(slot);
	endtask

	// Random record: branch types weighted up, and most branches steered to
	// land near the edge of their reach so both near and far paths get hit.
	function automatic req_t random_reloc();
		req_t r;
		logic [31:0] p, sa;
		r.op = ($urandom_range(0, 5) == 0) ? OP_SIZE : OP_APPLY;
		case ($urandom_range(0, 21))
		0:  r.reloc_type = R_NONE;
		1:  r.reloc_type = R_ADDR32;
		2:  r.reloc_type = R_ADDR16_LO;
		3:  r.reloc_type = R_ADDR16_HI;
		4:  r.reloc_type = R_ADDR16_HA;
		5:  r.reloc_type = R_REL32;
		6:  r.reloc_type = R_SDAREL16;
		7:  r.reloc_type = R_TPREL16_LO;
		8:  r.reloc_type = R_TPREL16_HI;
		9:  r.reloc_type = R_TPREL16_HA;
		10, 11, 12: r.reloc_type = R_ADDR24;
		13, 14, 15: r.reloc_type = R_ADDR14;
		16, 17, 18: r.reloc_type = R_REL24;
		19, 20: r.reloc_type = R_REL14;
		default: r.reloc_type = 8'($urandom_range(0, 255));
		endcase
		r.section_base = ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom;
		r.place_offset = ($urandom_range(0, 3) == 0) ? $urandom
			: ($urandom_range(0, 32'hffff) & ~32'h3);
		r.addend       = ($urandom_range(0, 2) == 0) ? $urandom
			: $urandom_range(0, 32'h1ff) - 32'h100;
		r.symbol_value = $urandom;
		r.old_word     = $urandom;
		if ($urandom_range(0, 3) != 0) begin
			p  = r.section_base + r.place_offset;
			sa = r.symbol_value + $unsigned(r.addend);
			case (r.reloc_type)
			R_REL14:  sa = p + $urandom_range(0, 32'h1ffff) - 32'h10000;
			R_REL24:  sa = p + $urandom_range(0, 32'h7ff_ffff) - 32'h400_0000;
			R_ADDR14: sa = $urandom_range(0, 32'h1ffff);
			R_ADDR24: sa = $urandom_range(0, 32'h7ff_ffff);
			default: ;
			endcase
			r.symbol_value = sa - $unsigned(r.addend);
		end
		return r;
	endfunction

	task automatic queue_random(input int n, input int drain_at);
		backlog_t slot;
		for (int i = 0; i < n; i++) begin
			slot.drain_first = (i == drain_at);
			slot.rec         = random_reloc();
			reloc_backlog.push_back(slot);
		end
	endtask

	initial begin
		logic [31:0] t0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: trampoline area holds exactly two veneers.
		write_reg(CFG_SMALL_BASE, 32'h0001_0000);
		write_reg(CFG_TRAMP_START, 32'h0000_2000);
		write_reg(CFG_TRAMP_END, 32'h0000_2020);
		queue_rec(reloc_rec(OP_APPLY, R_NONE, '0, '0, '0, '0, '0));
		queue_rec(reloc_rec(OP_APPLY, R_ADDR32, '1, '1, 32'h7fff_ffff, '1, '1));
		queue_rec(reloc_rec(OP_APPLY, R_REL32, D_BASE, D_OFF, 32'h8000_0000,
			32'h1234_5678, '0));
		queue_rec(reloc_rec(OP_APPLY, R_ADDR16_LO, D_BASE, D_OFF, '0, 32'h1234_8000, '0));
		queue_rec(reloc_rec(OP_APPLY, R_ADDR16_HI, D_BASE, D_OFF, '0, 32'h1234_8000, '0));
		// high adjusted with carry, and with carry wrapping to zero
		queue_rec(reloc_rec(OP_APPLY, R_ADDR16_HA, D_BASE, D_OFF, '0, 32'h1234_8000, '0));
		queue_rec(reloc_rec(OP_APPLY, R_ADDR16_HA, D_BASE, D_OFF, '0, 32'hffff_8000, '0));
		queue_rec(reloc_rec(OP_APPLY, R_TPREL16_LO, D_BASE, D_OFF, '1, 32'hdead_beef, '0));
		queue_rec(reloc_rec(OP_APPLY, R_TPREL16_HI, D_BASE, D_OFF, '1, 32'hdead_beef, '0));
		queue_rec(reloc_rec(OP_APPLY, R_TPREL16_HA, D_BASE, D_OFF, '0, 32'h0000_7fff, '0));
		queue_rec(reloc_rec(OP_APPLY, R_SDAREL16, D_BASE, D_OFF, 32'd4, 32'h0000_fffe, '0));
		// largest absolute targets still in reach
		queue_rec(reloc_rec(OP_APPLY, R_ADDR24, D_BASE, D_OFF, '0, 32'h03ff_fffc, '1));
		queue_rec(reloc_rec(OP_APPLY, R_ADDR14, D_BASE, D_OFF, '0, 32'h0000_fffc,
			32'h4800_0001));
		// relative reach edges: furthest back, furthest forward
		queue_rec(reloc_rec(OP_APPLY, R_REL24, D_BASE, D_OFF, '0, D_P - 32'h0200_0000,
			32'h4800_0000));
		queue_rec(reloc_rec(OP_APPLY, R_REL14, D_BASE, D_OFF, '0, D_P + 32'h7ffc,
			32'h4082_0000));
		// two veneers fill the area, the third branch finds no room
		queue_rec(reloc_rec(OP_APPLY, R_ADDR24, D_BASE, D_OFF, '0, 32'h0400_0000,
			32'h4800_0003));
		queue_rec(reloc_rec(OP_APPLY, R_REL14, D_BASE, D_OFF, 32'h10,
			D_P + 32'h8000 - 32'h10, 32'h4082_0001));
		queue_rec(reloc_rec(OP_APPLY, R_ADDR14, D_BASE, D_OFF, '0, 32'h0001_0000, '1));
		// sizing pass: unplaced section, far, near, non-branch, unknown type
		queue_rec(reloc_rec(OP_SIZE, R_ADDR24, '0, D_OFF, '0, 32'h0800_0000, '0));
		queue_rec(reloc_rec(OP_SIZE, R_REL24, D_BASE, D_OFF, '0, D_P + 32'h0200_0000, '0));
		queue_rec(reloc_rec(OP_SIZE, R_REL14, D_BASE, D_OFF, '0, D_P + 32'h100, '0));
		queue_rec(reloc_rec(OP_SIZE, R_ADDR16_HA, D_BASE, D_OFF, '0, 32'h1234_8000, '0));
		queue_rec(reloc_rec(OP_SIZE, 8'd255, D_BASE, D_OFF, '0, '0, '0));
		queue_rec(reloc_rec(OP_APPLY, 8'd3, D_BASE, D_OFF, '0, '0, '0));
		queue_rec(reloc_rec(OP_APPLY, 8'd128, D_BASE, D_OFF, '0, '0, '0));
		wait_idle();

		// Roomy area at a random spot; one record waits for a full drain.
		t0 = $urandom & 32'h7fff_fff0;
		write_reg(CFG_SMALL_BASE, $urandom);
		write_reg(CFG_TRAMP_START, t0);
		write_reg(CFG_TRAMP_END, t0 + 32'h400);
		write_reg(CFG_UNUSED, 32'hffff_ffff);
		queue_random(50, 30);
		wait_idle();

		// All ones: the area sits at the top, so no veneer ever fits.
		write_reg(CFG_SMALL_BASE, 32'hffff_ffff);
		write_reg(CFG_TRAMP_START, 32'hffff_fff0);
		write_reg(CFG_TRAMP_END, 32'hffff_ffff);
		queue_random(20, -1);
		wait_idle();

		// Zero base, room for three veneers at address zero.
		write_reg(CFG_SMALL_BASE, 32'h0);
		write_reg(CFG_TRAMP_START, 32'h0);
		write_reg(CFG_TRAMP_END, 32'h0000_0030);
		queue_random(30, 12);
		wait_idle();

		// Last stretch at full rate on both sides.
		t0 = $urandom & 32'h7fff_fff0;
		write_reg(CFG_SMALL_BASE, $urandom);
		write_reg(CFG_TRAMP_START, t0);
		write_reg(CFG_TRAMP_END, t0 + 32'h200);
		calm = 1'b1;
		queue_random(30, -1);
		wait_idle();

		$display("Run covered %0d relocation records (%0d sizing) and %0d result words.",
			records_sent, sizing_records, words_checked);
		$display("Veneers placed: %0d, refused for lack of room: %0d, register writes: %0d.",
			veneers_placed, room_refusals, reg_writes);
		if (mismatch_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/ppcrp_pkg.sv
hw/rtl/ppcrp_front.sv
hw/rtl/ppcrp_queue.sv
hw/rtl/ppcrp_back.sv
hw/rtl/ppc_relocation_patcher_top.sv
hw/rtl/ppcrp_checker.sv
tb/sv/tb_top.sv
